>>> hdl/dfr_pkg.sv
package dfr_pkg;
   localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
   localparam int          SIG_W     = 53;
   localparam int          EXP_W     = 13;

   typedef struct packed {
      logic             start;
      logic             done;
   } seq_ctl_type;
endpackage

>>> hdl/dfr_core.sv
module dfr_core
   import dfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a_bits,
   input  logic [63:0] b_bits,
   output logic        done,
   output logic [63:0] result
);
   typedef enum logic [2:0] {S_IDLE, S_NORMA, S_NORMB, S_DIV, S_NORMR, S_PACK} state_type;

   state_type                state_ff, state_in;
   logic [SIG_W:0]           ma_ff, ma_in;
   logic [SIG_W-1:0]         mb_ff, mb_in;
   logic signed [EXP_W-1:0]  ea_ff, ea_in, eb_ff, eb_in;
   logic                     sign_ff, sign_in;
   logic [63:0]              res_ff, res_in;
   logic                     done_ff, done_in;
   logic [SIG_W+1:0]         diff;
   logic [SIG_W-1:0]         rem;
   logic signed [EXP_W-1:0]  sh;

   assign diff = {1'b0, ma_ff} - {2'b00, mb_ff};
   assign rem  = diff[SIG_W+1] ? ma_ff[SIG_W-1:0] : diff[SIG_W-1:0];
   assign sh   = EXP_W'(signed'(1)) - eb_ff;

   always_comb begin
      state_in = state_ff;
      ma_in = ma_ff; mb_in = mb_ff; ea_in = ea_ff; eb_in = eb_ff;
      sign_in = sign_ff; res_in = res_ff; done_in = 1'b0;
      case (state_ff)
         S_IDLE: if (start) begin
            sign_in = a_bits[63];
            ma_in = {1'b0, (a_bits[62:52] != 11'd0), a_bits[51:0]};
            mb_in = {(b_bits[62:52] != 11'd0), b_bits[51:0]};
            ea_in = (a_bits[62:52] == 11'd0) ? EXP_W'(1) : EXP_W'(a_bits[62:52]);
            eb_in = (b_bits[62:52] == 11'd0) ? EXP_W'(1) : EXP_W'(b_bits[62:52]);
            state_in = S_NORMA;
         end
         S_NORMA: if (!ma_ff[SIG_W-1]) begin
            ma_in = {ma_ff[SIG_W-1:0], 1'b0}; ea_in = ea_ff - 1'b1;
         end else state_in = S_NORMB;
         S_NORMB: if (!mb_ff[SIG_W-1]) begin
            mb_in = {mb_ff[SIG_W-2:0], 1'b0}; eb_in = eb_ff - 1'b1;
         end else state_in = S_DIV;
         S_DIV: begin
            if (ea_ff > eb_ff) begin
               ma_in = {rem, 1'b0}; ea_in = ea_ff - 1'b1;
            end else begin
               ma_in = {1'b0, rem}; state_in = S_NORMR;
            end
         end
         S_NORMR: if (ma_ff == '0) begin
            res_in = {sign_ff, 63'd0}; done_in = 1'b1; state_in = S_IDLE;
         end else if (!ma_ff[SIG_W-1]) begin
            ma_in = {ma_ff[SIG_W-1:0], 1'b0}; eb_in = eb_ff - 1'b1;
         end else state_in = S_PACK;
         S_PACK: begin
            if (eb_ff >= EXP_W'(1))
               res_in = {sign_ff, eb_ff[10:0], ma_ff[51:0]};
            else if (sh >= EXP_W'(64))
               res_in = {sign_ff, 63'd0};
            else
               res_in = {sign_ff, 63'(64'(ma_ff) >> sh[5:0])};
            done_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ma_ff <= ma_in; mb_ff <= mb_in; ea_ff <= ea_in; eb_ff <= eb_in;
      sign_ff <= sign_in; res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

>>> hdl/double_float_remainder.sv
// Special cases go straight to the result register; other operands go through the
// core's normalize shifts, its one-bit-per-cycle shift-subtract loop and a pack step.
// Throughput: one item at a time; req_stall stays high from acceptance to result delivery.
// Reset: synchronous, active high; clears the sequencer and the result valid.
module double_float_remainder
   import dfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_a_bits,
   input  logic [63:0] req_b_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_rem_bits,
   output logic        rsp_domain_error
);
   typedef enum logic [1:0] {T_IDLE, T_BUSY, T_OUT} top_state_type;

   top_state_type state_ff;
   seq_ctl_type   ctl;
   logic [63:0]   core_res, rem_ff;
   logic          derr_ff, fast;
   logic [63:0]   amag, bmag;

   assign amag = req_a_bits & ~SIGN_MASK;
   assign bmag = req_b_bits & ~SIGN_MASK;
   assign fast = (bmag == 64'd0) || ((amag & EXP_MASK) == EXP_MASK) || (bmag >= EXP_MASK)
              || (amag == 64'd0) || (amag < bmag);

   assign req_stall = (state_ff != T_IDLE);
   assign ctl.start = req_valid && !req_stall && !fast;

   dfr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.start),
      .a_bits (req_a_bits),
      .b_bits (req_b_bits),
      .done   (ctl.done),
      .result (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         case (state_ff)
            T_IDLE: if (req_valid) begin
               derr_ff <= (bmag == 64'd0);
               if (fast) begin
                  rem_ff <= req_a_bits; state_ff <= T_OUT;
               end else state_ff <= T_BUSY;
            end
            T_BUSY: if (ctl.done) begin
               rem_ff <= core_res; state_ff <= T_OUT;
            end
            T_OUT: if (!rsp_stall) state_ff <= T_IDLE;
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_valid        = (state_ff == T_OUT);
   assign rsp_rem_bits     = rem_ff;
   assign rsp_domain_error = derr_ff;
endmodule

>>> hdl/dfr_checker.sv
module dfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_rem_bits,
   input logic        rsp_domain_error
);
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("not busy after accept");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_rem_bits)
         && $stable(rsp_domain_error))
      else $error("result dropped");
   a_free_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid) else $error("result repeated");
endmodule

bind double_float_remainder dfr_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_rem_bits(rsp_rem_bits),
   .rsp_domain_error(rsp_domain_error)
);
